### sv/pareto_archive_two_objectives_top_defines.svh
// Assertion macros shared by the Pareto archive checker.
`ifndef PARETO_ARCHIVE_TWO_OBJECTIVES_TOP_DEFINES_SVH
`define PARETO_ARCHIVE_TWO_OBJECTIVES_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PARC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("parc check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PARC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("parc check failed");

`endif

### sv/parc_pkg.sv
// Shared constants, codes and control structs of the Pareto archive.
package parc_pkg;

	localparam int ARCHIVE_DEPTH = 64;
	localparam int FRACTION_BITS = 16;
	localparam int IDX_W         = $clog2(ARCHIVE_DEPTH);
	localparam int CNT_W         = $clog2(ARCHIVE_DEPTH + 1);
	localparam int VAL_W         = 48;
	localparam int DIFF_W        = VAL_W + 1;
	localparam int TOL_W         = 21;
	localparam int STATUS_W      = 2;
	localparam int OUT_CNT_W     = 7;
	localparam int CFG_IDX_W     = 2;
	localparam int S_TDATA_W     = 96;
	localparam int M_TDATA_W     = 16;

	// Tolerance reset values: round(2^FRACTION_BITS * k), saturated to the field.
	localparam longint unsigned FB_ONE  = 64'd1 << FRACTION_BITS;
	localparam longint unsigned TOL_MAX = (64'd1 << TOL_W) - 64'd1;
	localparam longint unsigned FST_RAW = (FB_ONE + 64'd500000000) / 64'd1000000000;
	localparam longint unsigned LT_RAW  = (FB_ONE + 64'd500) / 64'd1000;
	localparam longint unsigned SPT_RAW = (FB_ONE + 64'd5000) / 64'd10000;
	localparam logic [TOL_W-1:0] FST_RESET = TOL_W'((FST_RAW > TOL_MAX) ? TOL_MAX : FST_RAW);
	localparam logic [TOL_W-1:0] LT_RESET  = TOL_W'((LT_RAW > TOL_MAX) ? TOL_MAX : LT_RAW);
	localparam logic [TOL_W-1:0] SPT_RESET = TOL_W'((SPT_RAW > TOL_MAX) ? TOL_MAX : SPT_RAW);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIRST_STRICT = 2'd0,
		CFG_LOOSE        = 2'd1,
		CFG_SAME_POINT   = 2'd2
	} cfg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_DOMINATED = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_COMMIT = 4'b1000
	} ctrl_state_t;

	typedef struct packed {
		logic             load;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             commit;
	} parc_cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} parc_sts_t;

endpackage

### sv/parc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module parc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### sv/parc_ctrl.sv
// Sequencer of the Pareto archive: accept, scan, drain, commit.
module parc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_valid,
	output logic                s_ready,
	output parc_pkg::parc_cmd_t cmd,
	input  parc_pkg::parc_sts_t sts
);
	import parc_pkg::*;

	ctrl_state_t      state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic             last_idx;

	assign last_idx = (idx_q == IDX_W'(ARCHIVE_DEPTH - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (last_idx) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!sts.pipe_busy) state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				idx_q <= '0;
			end else if (state_q == S_SCAN) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign s_ready     = (state_q == S_IDLE);
	assign cmd.load    = s_valid && (state_q == S_IDLE);
	assign cmd.rd_en   = (state_q == S_SCAN);
	assign cmd.rd_addr = idx_q;
	assign cmd.commit  = (state_q == S_COMMIT) && sts.out_free;
endmodule

### sv/parc_dp.sv
// Datapath: tolerances, archive RAMs, compare pipeline, flags, result register.
module parc_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  parc_pkg::parc_cmd_t                 cmd,
	output parc_pkg::parc_sts_t                 sts,
	input  logic signed [parc_pkg::VAL_W-1:0]   point_first,
	input  logic signed [parc_pkg::VAL_W-1:0]   point_second,
	input  logic                                restart,
	input  logic                                cfg_we,
	input  logic [parc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [parc_pkg::TOL_W-1:0]          cfg_data,
	output logic                                m_valid,
	input  logic                                m_ready,
	output logic [parc_pkg::STATUS_W-1:0]       status,
	output logic                                dominates_some,
	output logic [parc_pkg::OUT_CNT_W-1:0]      removed_count,
	output logic [parc_pkg::OUT_CNT_W-1:0]      archive_count
);
	import parc_pkg::*;

	// tolerances
	logic [TOL_W-1:0] fst_q, lt_q, spt_q;

	// current point
	logic signed [VAL_W-1:0] p1_q, p2_q;

	// archive bookkeeping
	logic [ARCHIVE_DEPTH-1:0] valid_q, valid_after;
	logic [CNT_W-1:0]         count_q, count_after;

	// read tag and compare stage
	logic                     rd_vld_s0;
	logic [IDX_W-1:0]         rd_idx_s0;
	logic [VAL_W-1:0]         e1_rd, e2_rd;
	logic signed [DIFF_W-1:0] d1, d2, n1, n2;
	logic signed [DIFF_W-1:0] d1_s1, d2_s1, n1_s1, n2_s1;
	logic                     vld_s1;
	logic [IDX_W-1:0]         idx_s1;

	// scan flags
	logic                     dup_q, rej_q, free_found_q;
	logic [ARCHIVE_DEPTH-1:0] kill_q;
	logic [CNT_W-1:0]         rem_q;
	logic [IDX_W-1:0]         free_idx_q;

	logic signed [DIFF_W-1:0] fst_x, lt_x, spt_x;
	logic                     ent_live, e_dom_p, p_dom_e, is_dup;
	logic                     keep_point, do_insert;

	// result register
	logic                 out_vld_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic                 out_dom_q;
	logic [OUT_CNT_W-1:0] out_rem_q, out_cnt_q;

	parc_ram #(.WIDTH(VAL_W), .DEPTH(ARCHIVE_DEPTH)) u_ram_first (
		.clk   (clk),
		.we    (do_insert),
		.waddr (free_idx_q),
		.wdata (p1_q),
		.re    (cmd.rd_en),
		.raddr (cmd.rd_addr),
		.rdata (e1_rd)
	);

	parc_ram #(.WIDTH(VAL_W), .DEPTH(ARCHIVE_DEPTH)) u_ram_second (
		.clk   (clk),
		.we    (do_insert),
		.waddr (free_idx_q),
		.wdata (p2_q),
		.re    (cmd.rd_en),
		.raddr (cmd.rd_addr),
		.rdata (e2_rd)
	);

	// exact 49-bit differences, both directions
	always_comb begin
		d1 = $signed({e1_rd[VAL_W-1], e1_rd}) - $signed({p1_q[VAL_W-1], p1_q});
		d2 = $signed({e2_rd[VAL_W-1], e2_rd}) - $signed({p2_q[VAL_W-1], p2_q});
		n1 = $signed({p1_q[VAL_W-1], p1_q}) - $signed({e1_rd[VAL_W-1], e1_rd});
		n2 = $signed({p2_q[VAL_W-1], p2_q}) - $signed({e2_rd[VAL_W-1], e2_rd});
	end

	assign fst_x = $signed({{(DIFF_W-TOL_W){1'b0}}, fst_q});
	assign lt_x  = $signed({{(DIFF_W-TOL_W){1'b0}}, lt_q});
	assign spt_x = $signed({{(DIFF_W-TOL_W){1'b0}}, spt_q});

	// d = entry - point, n = point - entry
	assign ent_live = vld_s1 && valid_q[idx_s1];
	assign e_dom_p  = !(d1_s1 > fst_x) && !(d2_s1 > lt_x) && ((n1_s1 > lt_x) || (n2_s1 > lt_x));
	assign p_dom_e  = !(n1_s1 > fst_x) && !(n2_s1 > lt_x) && ((d1_s1 > lt_x) || (d2_s1 > lt_x));
	assign is_dup   = (d1_s1 < spt_x) && (n1_s1 < spt_x) && (d2_s1 < spt_x) && (n2_s1 < spt_x);

	assign keep_point = !dup_q && !rej_q;
	assign do_insert  = cmd.commit && keep_point && free_found_q;

	always_comb begin
		valid_after = valid_q & ~kill_q;
		if (free_found_q) valid_after[free_idx_q] = 1'b1;
		count_after = count_q - rem_q + {{(CNT_W-1){1'b0}}, free_found_q};
	end

	assign sts.pipe_busy = rd_vld_s0 || vld_s1;
	assign sts.out_free  = !out_vld_q || m_ready;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q        <= FST_RESET;
			lt_q         <= LT_RESET;
			spt_q        <= SPT_RESET;
			valid_q      <= '0;
			count_q      <= '0;
			rd_vld_s0    <= 1'b0;
			vld_s1       <= 1'b0;
			dup_q        <= 1'b0;
			rej_q        <= 1'b0;
			free_found_q <= 1'b0;
			kill_q       <= '0;
			rem_q        <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FIRST_STRICT: fst_q <= cfg_data;
					CFG_LOOSE:        lt_q  <= cfg_data;
					CFG_SAME_POINT:   spt_q <= cfg_data;
					default:          ;
				endcase
			end

			rd_vld_s0 <= cmd.rd_en;
			vld_s1    <= rd_vld_s0;

			if (cmd.load) begin
				dup_q        <= 1'b0;
				rej_q        <= 1'b0;
				free_found_q <= 1'b0;
				kill_q       <= '0;
				rem_q        <= '0;
				if (restart) begin
					valid_q <= '0;
					count_q <= '0;
				end
			end else if (vld_s1) begin
				if (ent_live) begin
					if (is_dup) dup_q <= 1'b1;
					if (e_dom_p) rej_q <= 1'b1;
					if (p_dom_e) begin
						kill_q[idx_s1] <= 1'b1;
						rem_q          <= rem_q + 1'b1;
					end
				end
				// lowest slot that is free once the removals apply
				if (!free_found_q && (!valid_q[idx_s1] || (ent_live && p_dom_e))) begin
					free_found_q <= 1'b1;
				end
			end

			if (cmd.commit && keep_point) begin
				valid_q <= valid_after;
				count_q <= count_after;
			end

			if (cmd.commit) begin
				out_vld_q <= 1'b1;
			end else if (m_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p1_q <= point_first;
			p2_q <= point_second;
		end
		rd_idx_s0 <= cmd.rd_addr;
		idx_s1    <= rd_idx_s0;
		d1_s1     <= d1;
		d2_s1     <= d2;
		n1_s1     <= n1;
		n2_s1     <= n2;
		if (vld_s1 && !free_found_q && (!valid_q[idx_s1] || (ent_live && p_dom_e))) begin
			free_idx_q <= idx_s1;
		end
		if (cmd.commit) begin
			if (dup_q) begin
				out_status_q <= ST_DUPLICATE;
				out_dom_q    <= 1'b0;
				out_rem_q    <= '0;
				out_cnt_q    <= OUT_CNT_W'(count_q);
			end else if (rej_q) begin
				out_status_q <= ST_DOMINATED;
				out_dom_q    <= 1'b0;
				out_rem_q    <= '0;
				out_cnt_q    <= OUT_CNT_W'(count_q);
			end else begin
				out_status_q <= free_found_q ? ST_INSERTED : ST_FULL;
				out_dom_q    <= (rem_q != '0);
				out_rem_q    <= OUT_CNT_W'(rem_q);
				out_cnt_q    <= OUT_CNT_W'(count_after);
			end
		end
	end

	assign m_valid        = out_vld_q;
	assign status         = out_status_q;
	assign dominates_some = out_dom_q;
	assign removed_count  = out_rem_q;
	assign archive_count  = out_cnt_q;
endmodule

### sv/pareto_archive_two_objectives_top.sv
// Top level of the two-objective Pareto archive: stream ports, control and datapath.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | point_first, point_second; restart in tuser
//  m_*      | out | m_tvalid/m_tready  | dominates_some, counts; status in tuser
//  cfg_*    | in  | cfg_we (no wait)   | tolerance register index and value
//
// Each input beat is handled in order: one archive entry is read per cycle
// through the single read port of the archive RAMs, two compare stages drain,
// then a commit updates the archive.
// The result sits in an output register; the next beat is taken as soon as the
// commit is done, even while that result still waits on m_tready. A commit waits
// only if the previous result was not yet taken. arst_n empties the archive and
// loads the default tolerances; archive RAM contents need no clearing.
module pareto_archive_two_objectives_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [47:0] point_first, [95:48] point_second
	input  logic [parc_pkg::S_TDATA_W-1:0]       s_tdata,
	// [0] restart
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [0] dominates_some, [7:1] removed_count, [14:8] archive_count, [15] zero
	output logic [parc_pkg::M_TDATA_W-1:0]       m_tdata,
	// [1:0] status
	output logic [parc_pkg::STATUS_W-1:0]        m_tuser,
	input  logic                                 cfg_we,
	input  logic [parc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [parc_pkg::TOL_W-1:0]           cfg_data
);
	import parc_pkg::*;

	parc_cmd_t cmd;
	parc_sts_t sts;

	logic signed [VAL_W-1:0] point_first, point_second;
	logic                    dominates_some;
	logic [OUT_CNT_W-1:0]    removed_count, archive_count;

	// unpack the input beat
	assign point_first  = $signed(s_tdata[VAL_W-1:0]);
	assign point_second = $signed(s_tdata[2*VAL_W-1:VAL_W]);

	parc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.s_ready (s_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	parc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.point_first    (point_first),
		.point_second   (point_second),
		.restart        (s_tuser),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.m_valid        (m_tvalid),
		.m_ready        (m_tready),
		.status         (m_tuser),
		.dominates_some (dominates_some),
		.removed_count  (removed_count),
		.archive_count  (archive_count)
	);

	// pack the result beat, zero pad to whole bytes
	assign m_tdata = {{(M_TDATA_W - 1 - 2*OUT_CNT_W){1'b0}},
		archive_count, removed_count, dominates_some};
endmodule

### sv/parc_checker.sv
// Port-level checks of the Pareto archive, bound to the top level.
`include "pareto_archive_two_objectives_top_defines.svh"

module parc_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic [parc_pkg::S_TDATA_W-1:0]       s_tdata,
	input logic                                 s_tuser,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [parc_pkg::M_TDATA_W-1:0]       m_tdata,
	input logic [parc_pkg::STATUS_W-1:0]        m_tuser,
	input logic                                 cfg_we,
	input logic [parc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input logic [parc_pkg::TOL_W-1:0]           cfg_data
);
	import parc_pkg::*;

	// a held result stays offered
	`PARC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	// an accepted point keeps the block busy for its scan
	`PARC_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	// duplicate or dominated points remove nothing
	`PARC_ASSERT_IMP(a_no_removal, m_tvalid && (m_tuser == ST_DUPLICATE || m_tuser == ST_DOMINATED), m_tdata[7:0] == 8'd0)
	// an inserted point leaves the archive non-empty
	`PARC_ASSERT_IMP(a_insert_nonempty, m_tvalid && (m_tuser == ST_INSERTED), m_tdata[14:8] != 7'd0)
	// dominates flag agrees with the removal count
	`PARC_ASSERT_IMP(a_dom_flag, m_tvalid, m_tdata[0] == (m_tdata[7:1] != 7'd0))
endmodule

bind pareto_archive_two_objectives_top parc_checker u_parc_checker (.*);

### sim/pareto_archive_checker.sv
`timescale 1ns / 100ps
// Pareto archive checker: predicts each result beat from accepted points and compares it.
module pareto_archive_checker
	import parc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [S_TDATA_W-1:0]   s_tdata,
	input  logic                   s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [M_TDATA_W-1:0]   m_tdata,
	input  logic [STATUS_W-1:0]    m_tuser,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [TOL_W-1:0]       cfg_data,
	output int                     failures,
	output int                     pending
);

	typedef struct packed {
		status_t              status;
		logic                 dominates_some;
		logic [OUT_CNT_W-1:0] removed_count;
		logic [OUT_CNT_W-1:0] archive_count;
	} verdict_t;

	localparam logic [TOL_W-1:0] FIRST_STRICT_INIT = 21'd0;
	localparam logic [TOL_W-1:0] LOOSE_INIT        = 21'd66;
	localparam logic [TOL_W-1:0] SAME_POINT_INIT   = 21'd7;

	logic signed [VAL_W-1:0] kept_first  [ARCHIVE_DEPTH];
	logic signed [VAL_W-1:0] kept_second [ARCHIVE_DEPTH];
	logic                    kept_valid  [ARCHIVE_DEPTH];
	int                      kept_count;
	logic [TOL_W-1:0]        tol_first_strict;
	logic [TOL_W-1:0]        tol_loose;
	logic [TOL_W-1:0]        tol_same_point;
	verdict_t                expected_verdicts [$];

	// exact 49-bit difference a - b
	function automatic logic signed [DIFF_W-1:0] gap(input logic signed [VAL_W-1:0] a,
			input logic signed [VAL_W-1:0] b);
		return DIFF_W'(a) - DIFF_W'(b);
	endfunction

	function automatic logic signed [DIFF_W-1:0] widen(input logic [TOL_W-1:0] t);
		return $signed(DIFF_W'(t));
	endfunction

	function automatic logic point_dominates(input logic signed [VAL_W-1:0] a1,
			input logic signed [VAL_W-1:0] a2, input logic signed [VAL_W-1:0] b1,
			input logic signed [VAL_W-1:0] b2);
		if (gap(a1, b1) > widen(tol_first_strict))
			return 1'b0;
		if (gap(a2, b2) > widen(tol_loose))
			return 1'b0;
		return (gap(b1, a1) > widen(tol_loose)) || (gap(b2, a2) > widen(tol_loose));
	endfunction

	function automatic logic close_to(input logic signed [VAL_W-1:0] a,
			input logic signed [VAL_W-1:0] b);
		return (gap(a, b) < widen(tol_same_point)) && (gap(b, a) < widen(tol_same_point));
	endfunction

	task automatic classify_point(input logic signed [VAL_W-1:0] p1,
			input logic signed [VAL_W-1:0] p2, input logic restart, output verdict_t v);
		logic duplicate;
		logic rejected;
		int   removed;
		duplicate = 1'b0;
		rejected  = 1'b0;
		removed   = 0;
		if (restart) begin
			foreach (kept_valid[i])
				kept_valid[i] = 1'b0;
			kept_count = 0;
		end
		foreach (kept_valid[i])
			if (kept_valid[i] && close_to(p1, kept_first[i]) && close_to(p2, kept_second[i]))
				duplicate = 1'b1;
		if (!duplicate)
			foreach (kept_valid[i])
				if (kept_valid[i] && point_dominates(kept_first[i], kept_second[i], p1, p2))
					rejected = 1'b1;
		if (duplicate) begin
			v.status = ST_DUPLICATE;
		end else if (rejected) begin
			v.status = ST_DOMINATED;
		end else begin
			foreach (kept_valid[i])
				if (kept_valid[i] && point_dominates(p1, p2, kept_first[i], kept_second[i])) begin
					kept_valid[i] = 1'b0;
					removed++;
				end
			kept_count -= removed;
			v.status = ST_FULL;
			for (int i = 0; i < ARCHIVE_DEPTH; i++) begin
				if (!kept_valid[i]) begin
					kept_first[i]  = p1;
					kept_second[i] = p2;
					kept_valid[i]  = 1'b1;
					kept_count++;
					v.status = ST_INSERTED;
					break;
				end
			end
		end
		v.dominates_some = (removed != 0);
		v.removed_count  = OUT_CNT_W'(removed);
		v.archive_count  = OUT_CNT_W'(kept_count);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t want;
		if (!arst_n) begin
			foreach (kept_valid[i])
				kept_valid[i] = 1'b0;
			kept_count       = 0;
			tol_first_strict = FIRST_STRICT_INIT;
			tol_loose        = LOOSE_INIT;
			tol_same_point   = SAME_POINT_INIT;
			expected_verdicts.delete();
			failures = 0;
			pending  = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FIRST_STRICT: tol_first_strict = cfg_data;
					CFG_LOOSE:        tol_loose = cfg_data;
					CFG_SAME_POINT:   tol_same_point = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				classify_point(s_tdata[VAL_W-1:0], s_tdata[2*VAL_W-1:VAL_W], s_tuser, want);
				expected_verdicts = {expected_verdicts, want};
			end
			if (m_tvalid && m_tready) begin
				if (expected_verdicts.size() == 0) begin
					$error("result beat with no point pending: tdata=%h tuser=%h", m_tdata, m_tuser);
					failures++;
				end else begin
					want = expected_verdicts.pop_front();
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser);
						failures++;
					end
					if (m_tdata[0] !== want.dominates_some) begin
						$error("dominates_some: expected %0d, got %0d", want.dominates_some,
							m_tdata[0]);
						failures++;
					end
					if (m_tdata[7:1] !== want.removed_count) begin
						$error("removed_count: expected %0d, got %0d", want.removed_count,
							m_tdata[7:1]);
						failures++;
					end
					if (m_tdata[14:8] !== want.archive_count) begin
						$error("archive_count: expected %0d, got %0d", want.archive_count,
							m_tdata[14:8]);
						failures++;
					end
					if (m_tdata[15] !== 1'b0) begin
						$error("tdata pad: expected 0, got %0d", m_tdata[15]);
						failures++;
					end
				end
			end
			pending = expected_verdicts.size();
		end
	end

endmodule

### sim/tb_pareto_archive_two_objectives_top.sv
`timescale 1ns / 100ps
// Testbench top of the Pareto archive: stimulus, backpressure and the final verdict.
module tb_pareto_archive_two_objectives_top;
	import parc_pkg::*;

	localparam int unsigned RUN_LIMIT   = 1_000_000;
	localparam int          BLOCK_BEATS = 96;    // input beats per tolerance setting, then the block ends
	localparam int          TAIL_CYCLES = 100;   // > one full archive pass
	localparam int          HOLD_CYCLES = 800;   // long sink stall, fills the block
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
	localparam longint VAL_MAX      = 64'sd140737488355327;
	localparam longint VAL_MIN      = -64'sd140737488355328;
	localparam longint TOL_ALL_ONES = 64'sd2097151;
	localparam longint TOL_TOP      = 64'sd1048576;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic                 s_tuser   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TOL_W-1:0]     cfg_data  = '0;

	int          failures;
	int          pending;
	int          send_idle_pct = 12;
	int          recv_idle_pct = 82;
	int          hold_cycles   = 0;
	int          points_sent   = 0;
	int unsigned cycle_count   = 0;

	// local copy of the tolerances, only used to shape the point clouds
	longint tol_fst   = 0;
	longint tol_loose = 66;
	longint tol_same  = 7;

	always #2 clk = ~clk;

	pareto_archive_two_objectives_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pareto_archive_checker archive_watch (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.failures  (failures),
		.pending   (pending)
	);

	// Watchdog: a hung handshake or a lost result ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result sink. Drops tready at random, or for a counted stretch when the
	// stimulus asks for a hold-off (hold_cycles is only set right after a rising edge).
	initial begin
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_tready = 1'b0;
				hold_cycles--;
			end else begin
				m_tready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Signed random value spread over the given number of bits.
	function automatic longint rand_span(input int bits);
		longint r;
		r = {$urandom, $urandom};
		return r >>> (64 - bits);
	endfunction

	// Uniform offset in [-t, t]; the ends land exactly on a tolerance edge.
	function automatic longint jitter(input longint t);
		return longint'($urandom_range(32'(2 * t))) - t;
	endfunction

	function automatic longint widest_tol();
		longint w;
		w = tol_fst;
		if (tol_loose > w)
			w = tol_loose;
		if (tol_same > w)
			w = tol_same;
		return w;
	endfunction

	// Mostly small margins, now and then up to the top of the range.
	function automatic longint rand_tol();
		if ($urandom_range(3) == 0)
			return longint'($urandom_range(32'(TOL_TOP)));
		return longint'($urandom_range(300));
	endfunction

	// One input beat. Entered and left at a falling edge; tvalid stays high
	// for the next call so back-to-back beats need no gap.
	task automatic send_point(input longint first, input longint second, input logic restart);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {VAL_W'(second), VAL_W'(first)};
		s_tuser  = restart;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		points_sent++;
	endtask

	// Stop offering points until every result beat has come back.
	task automatic settle();
		s_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TOL_W-1:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic set_tolerances(input longint fst, input longint loose, input longint same);
		write_reg(CFG_FIRST_STRICT, TOL_W'(fst));
		write_reg(CFG_LOOSE, TOL_W'(loose));
		write_reg(CFG_SAME_POINT, TOL_W'(same));
		tol_fst   = fst;
		tol_loose = loose;
		tol_same  = same;
	endtask

	// Hand-picked points under the reset tolerances: field extremes, every
	// status except full, restarts, and both sides of each margin.
	task automatic directed_points();
		send_point(0, 0, 1'b1);                                   // empty archive
		send_point(tol_same - 1, 1 - tol_same, 1'b0);             // inside same-point margin
		send_point(tol_same, 0, 1'b0);                            // just outside it
		send_point(VAL_MIN, VAL_MAX, 1'b0);                       // opposite corners
		send_point(VAL_MAX, VAL_MIN, 1'b0);
		send_point(VAL_MAX, VAL_MAX, 1'b0);                       // worst in both
		send_point(-100, -100, 1'b0);                             // beats the origin group
		send_point(VAL_MIN, VAL_MIN, 1'b0);                       // beats everything
		send_point(VAL_MIN + tol_loose, VAL_MIN, 1'b0);           // on the loose edge
		send_point(VAL_MIN + tol_loose + 1, VAL_MIN + 1, 1'b0);   // past the loose edge
		send_point(VAL_MIN, VAL_MIN + tol_loose, 1'b0);
		send_point(VAL_MIN, VAL_MIN + tol_loose + 1, 1'b0);
		send_point(VAL_MIN + 1, VAL_MIN - 1 + tol_same, 1'b0);    // near the corner point
		send_point(VAL_MAX, VAL_MAX, 1'b1);                       // restart, then reuse
		send_point(VAL_MAX, VAL_MAX, 1'b0);
		send_point(VAL_MAX - 1, VAL_MIN, 1'b1);
		send_point(VAL_MIN, VAL_MAX - 1, 1'b0);
		send_point(0, 0, 1'b0);
		send_point(-1, -1, 1'b0);
		send_point(tol_fst + 1, -tol_loose - 1, 1'b0);            // first-objective edge
	endtask

	// Anti-diagonal front: up to enough mutually non-dominated points to fill the
	// archive and overflow it, with near-duplicates and dominated points mixed
	// in, sometimes closed by one point that sweeps a slice of the front.
	task automatic front_run();
		longint first_at  [0:79];
		longint second_at [0:79];
		longint wide;
		longint step;
		longint base1;
		longint base2;
		int     n;
		int     j;
		int     k;
		wide  = widest_tol();
		n     = $urandom_range(56, 72);
		if ($urandom_range(4) == 0)
			step = longint'($urandom_range(32'(2 * wide + 2), 1));   // spacing near the margins
		else
			step = wide + 1 + longint'($urandom_range(32'(wide + 64)));
		base1 = rand_span(45);
		base2 = rand_span(45);
		for (int i = 0; i < n; i++) begin
			first_at[i]  = base1 + i * step;
			second_at[i] = base2 - i * step;
			send_point(first_at[i], second_at[i], i == 0);
			case ($urandom_range(19))
				0: send_point(first_at[i] + jitter(tol_same), second_at[i] + jitter(tol_same),
						1'b0);
				1: send_point(first_at[i] + tol_loose + 1 + $urandom_range(40),
						second_at[i] + $urandom_range(40), 1'b0);
				default: ;
			endcase
		end
		if ($urandom_range(1)) begin
			j = $urandom_range(n - 1);
			k = $urandom_range(n - 1, j);
			send_point(first_at[j] - 1 - $urandom_range(32'(tol_loose)),
				second_at[k] - tol_loose - 1 - $urandom_range(32'(tol_loose)), 1'b0);
		end
	endtask

	// Tight cloud a few margins wide: duplicates, rejections and removals
	// right at the tolerance edges. Sometimes pinned against the value limits.
	task automatic cloud_run();
		longint w;
		longint c1;
		longint c2;
		int     n;
		n = $urandom_range(16, 40);
		w = 2 * widest_tol() + 8;
		case ($urandom_range(9))
			0:       c1 = VAL_MAX - w;
			1:       c1 = VAL_MIN + w;
			default: c1 = rand_span(46);
		endcase
		case ($urandom_range(9))
			0:       c2 = VAL_MAX - w;
			1:       c2 = VAL_MIN + w;
			default: c2 = rand_span(46);
		endcase
		for (int i = 0; i < n; i++)
			send_point(c1 + jitter(w), c2 + jitter(w), i == 0);
	endtask

	// Full-range noise: every bit of both objectives, restart now and then.
	task automatic noise_run();
		int n;
		n = $urandom_range(4, 12);
		for (int i = 0; i < n; i++)
			send_point(rand_span(48), rand_span(48), $urandom_range(7) == 0);
	endtask

	task automatic run_block();
		int stop_at;
		int pick;
		stop_at = points_sent + BLOCK_BEATS;
		while (points_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 40)
				front_run();
			else if (pick < 80)
				cloud_run();
			else
				noise_run();
		end
	endtask

	initial begin : stimulus
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed_points();

		// Three idle profiles, three tolerance settings each.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 12;
					recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 12;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int blk = 0; blk < 3; blk++) begin
				// registers only change with nothing in flight
				settle();
				case (phase * 3 + blk)
					0: ;   // keep the reset tolerances
					1: begin
						set_tolerances(0, 0, 0);
						write_reg(CFG_UNMAPPED, TOL_W'($urandom));   // must be ignored
					end
					2:       set_tolerances(TOL_ALL_ONES, TOL_ALL_ONES, TOL_ALL_ONES);
					3:       set_tolerances(TOL_TOP, TOL_TOP, TOL_TOP);
					default: set_tolerances(rand_tol(), rand_tol(), rand_tol());
				endcase
				if (phase == 2 && blk == 0) begin
					// long sink stall while points keep coming: input must back up
					@(posedge clk);
					hold_cycles = HOLD_CYCLES;
					@(negedge clk);
				end
				run_block();
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
